// ===== hdl/g2r_pkg.sv =====
// Shared types and constants for the wildcard-to-regex converter.
`default_nettype none

package g2r_pkg;

  localparam int MaxBytes = 8;
  localparam int IdxW     = $clog2(MaxBytes);

  typedef logic [MaxBytes-1:0][7:0] byte_vec_t;

  // Expansion of one item: bytes in emission order and index of the final one.
  typedef struct packed {
    byte_vec_t       bytes;
    logic [IdxW-1:0] last_idx;
  } seq_t;

endpackage

`default_nettype wire

// ===== hdl/g2r_if.sv =====
// Valid/ready channel interfaces for pattern input, regex output and configuration.
`default_nettype none

interface g2r_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_in;

  modport source (output valid, output action, output char_in, input ready);
  modport sink   (input valid, input action, input char_in, output ready);
endinterface

interface g2r_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface g2r_cfg_if;
  logic valid;
  logic ready;
  logic anchor_whole;

  modport source (output valid, output anchor_whole, input ready);
  modport sink   (input valid, input anchor_whole, output ready);
endinterface

`default_nettype wire

// ===== hdl/g2r_expand.sv =====
// Pattern state and expansion of one pattern item into its regex bytes.
`default_nettype none

module g2r_expand
  import g2r_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       action_i,
  input  logic [7:0] char_in_i,
  input  logic       anchor_i,
  output seq_t       seq_o
);

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChCaret  = 8'h5e;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChN      = 8'h6e;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChStar   = 8'h2a;
  localparam logic [7:0] ChQuest  = 8'h3f;
  localparam logic [7:0] ChLbrk   = 8'h5b;
  localparam logic [7:0] ChRbrk   = 8'h5d;
  localparam logic [7:0] ChLbrace = 8'h7b;
  localparam logic [7:0] ChRbrace = 8'h7d;
  localparam logic [7:0] ChLpar   = 8'h28;
  localparam logic [7:0] ChRpar   = 8'h29;
  localparam logic [7:0] ChPlus   = 8'h2b;

  localparam int BodyMax = MaxBytes - 1;

  logic at_start_q, at_start_d;
  logic after_bracket_q, after_bracket_d;
  logic escape_pending_q, escape_pending_d;

  logic [BodyMax-1:0][7:0] body;
  logic [IdxW-1:0]         body_last;
  logic                    caret;
  logic                    needs_esc;

  assign needs_esc = (char_in_i == ChDollar) || (char_in_i == ChCaret) ||
                     (char_in_i == ChLbrace) || (char_in_i == ChRbrace) ||
                     (char_in_i == ChLpar)   || (char_in_i == ChRpar)   ||
                     (char_in_i == ChDot)    || (char_in_i == ChPlus);

  assign caret = at_start_q & anchor_i;

  always_comb begin
    body             = '0;
    body_last        = '0;
    at_start_d       = 1'b0;
    after_bracket_d  = 1'b0;
    escape_pending_d = 1'b0;
    if (action_i) begin
      at_start_d = 1'b1;
      if (anchor_i) begin
        body[0]   = ChDollar;
        body[1]   = ChNul;
        body_last = IdxW'(1);
      end else begin
        body[0] = ChNul;
      end
    end else if (escape_pending_q) begin
      if (char_in_i == ChN) begin
        body[0]   = ChBslash;
        body[1]   = char_in_i;
        body_last = IdxW'(1);
      end else begin
        body[0] = char_in_i;
      end
    end else if (after_bracket_q && char_in_i == ChBang) begin
      body[0] = ChCaret;
    end else if (at_start_q && char_in_i == ChStar) begin
      body[0]   = ChLbrk;
      body[1]   = ChCaret;
      body[2]   = ChBslash;
      body[3]   = ChDot;
      body[4]   = ChRbrk;
      body[5]   = ChDot;
      body[6]   = ChStar;
      body_last = IdxW'(6);
    end else if (at_start_q && char_in_i == ChQuest) begin
      body[0]   = ChLbrk;
      body[1]   = ChCaret;
      body[2]   = ChBslash;
      body[3]   = ChDot;
      body[4]   = ChRbrk;
      body_last = IdxW'(4);
    end else if (char_in_i == ChQuest) begin
      body[0] = ChDot;
    end else if (char_in_i == ChStar) begin
      body[0]   = ChDot;
      body[1]   = ChStar;
      body_last = IdxW'(1);
    end else if (char_in_i == ChLbrk) begin
      body[0]         = ChLbrk;
      after_bracket_d = 1'b1;
    end else if (char_in_i == ChBslash) begin
      body[0]          = ChBslash;
      escape_pending_d = 1'b1;
    end else if (needs_esc) begin
      body[0]   = ChBslash;
      body[1]   = char_in_i;
      body_last = IdxW'(1);
    end else begin
      body[0] = char_in_i;
    end
  end

  // Leading anchor shifts the body up by one place.
  always_comb begin
    seq_o = '0;
    if (caret) begin
      seq_o.bytes[0] = ChCaret;
      for (int i = 0; i < BodyMax; i++) begin
        seq_o.bytes[i+1] = body[i];
      end
      seq_o.last_idx = body_last + IdxW'(1);
    end else begin
      for (int i = 0; i < BodyMax; i++) begin
        seq_o.bytes[i] = body[i];
      end
      seq_o.last_idx = body_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q       <= 1'b1;
      after_bracket_q  <= 1'b0;
      escape_pending_q <= 1'b0;
    end else if (accept_i) begin
      at_start_q       <= at_start_d;
      after_bracket_q  <= after_bracket_d;
      escape_pending_q <= escape_pending_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/g2r_emit.sv =====
// Result register holding one expanded item and sending it out a byte per cycle while the output is ready.
`default_nettype none

module g2r_emit
  import g2r_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_valid_i,
  output logic        load_ready_o,
  input  seq_t        seq_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o
);

  seq_t            buf_q;
  logic [IdxW-1:0] idx_q;
  logic            valid_q;
  logic            is_last;
  logic            take;
  logic            load;

  assign is_last      = (idx_q == buf_q.last_idx);
  assign take         = valid_q & out_ready_i;
  assign load_ready_o = ~valid_q | (take & is_last);
  assign load         = load_valid_i & load_ready_o;

  assign out_valid_o = valid_q;
  assign out_byte_o  = buf_q.bytes[idx_q];
  assign out_last_o  = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (take) begin
      if (is_last) begin
        valid_q <= 1'b0;
      end
      idx_q <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q <= seq_i;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> idx_q <= buf_q.last_idx)
    else $error("byte index beyond end of item");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_q && idx_q == '0)
    else $error("new item does not start at its first byte");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !(out_ready_i && is_last)) |-> !load_ready_o)
    else $error("item overwritten before its last byte left");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !is_last && !load) |=> valid_q && idx_q == $past(idx_q) + IdxW'(1))
    else $error("byte index did not advance");
`endif

endmodule

`default_nettype wire

// ===== hdl/glob_to_regex_converter.sv =====
// Top level: shell wildcard pattern in, equivalent regular expression out.
`default_nettype none

// Pattern bytes enter on pat_i, one per item; an item with action set ends the
// pattern. Each item expands to between one and eight regex bytes, which leave
// on rx_o one per cycle while rx_o is ready, with out_last on the final byte of
// the item; the end item yields the closing anchor (when anchoring is on, after
// the opening one if the pattern was empty) and a NUL. An item is expanded as it
// is accepted and held in a single result buffer, and the next item is accepted
// in the same cycle as the last byte of the previous one is taken: throughput is
// one output byte per cycle while rx_o is ready. Anchoring is set through
// cfg_i (reset value 1) and must only change while the block is idle.
module glob_to_regex_converter
  import g2r_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  g2r_cfg_if.sink   cfg_i,
  g2r_in_if.sink    pat_i,
  g2r_out_if.source rx_o
);

  logic anchor_q;
  logic accept;
  seq_t seq;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_q <= 1'b1;
    end else if (cfg_i.valid) begin
      anchor_q <= cfg_i.anchor_whole;
    end
  end

  assign accept = pat_i.valid & pat_i.ready;

  g2r_expand u_expand (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .action_i  (pat_i.action),
    .char_in_i (pat_i.char_in),
    .anchor_i  (anchor_q),
    .seq_o     (seq)
  );

  g2r_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (pat_i.valid),
    .load_ready_o (pat_i.ready),
    .seq_i        (seq),
    .out_valid_o  (rx_o.valid),
    .out_ready_i  (rx_o.ready),
    .out_byte_o   (rx_o.out_byte),
    .out_last_o   (rx_o.out_last)
  );

endmodule

`default_nettype wire

// ===== test/glob_to_regex_converter_tb.sv =====
// Self-checking testbench for glob_to_regex_converter: directed and random patterns.
`timescale 1ns / 1ps

module glob_to_regex_converter_tb;
  import g2r_pkg::*;

  localparam logic ActChar = 1'b0;
  localparam logic ActEnd  = 1'b1;

  localparam logic [7:0] ChStar   = "*";
  localparam logic [7:0] ChQuest  = "?";
  localparam logic [7:0] ChOpen   = "[";
  localparam logic [7:0] ChBang   = "!";
  localparam logic [7:0] ChBslash = "\\";
  localparam logic [7:0] ChN      = "n";

  localparam string LeadStar  = "[^\\.].*";
  localparam string LeadQuest = "[^\\.]";

  localparam logic [7:0] GlobChars [16] = '{"*", "?", "[", "!", "\\", "n", "$", "^",
                                            "{", "}", "(", ")", ".", "+", "]", "a"};

  localparam int WatchLimit   = 2000;
  localparam int SettleCycles = 16;

  typedef struct {
    logic       act;
    logic [7:0] ch;
    int         gap;
    bit         drain;
  } glob_item_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last;
  } regex_byte_t;

  logic clk;
  logic rst_n;

  g2r_cfg_if cfg ();
  g2r_in_if  pat ();
  g2r_out_if rx ();

  glob_to_regex_converter dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg),
    .pat_i  (pat),
    .rx_o   (rx)
  );

  glob_item_t  pend_q[$];
  regex_byte_t regex_q[$];
  logic [7:0]  item_bytes[$];

  // predictor state
  logic anchor_cfg;
  logic at_start;
  logic after_bracket;
  logic escape_pending;

  int         err_count;
  int         gap_waited;
  int         stall_left;
  int         next_stall;
  int         quiet_cycles;
  bit         no_idle;
  bit         rx_drained;
  glob_item_t cur_item;
  regex_byte_t want;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) item_bytes.push_back(s[i]);
  endfunction

  function automatic bit is_meta(input logic [7:0] c);
    case (c)
      "$", "^", "{", "}", "(", ")", ".", "+": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic expand_glob_item(input logic act, input logic [7:0] c);
    logic first;
    logic brk;
    logic esc;
    item_bytes.delete();
    if (act == ActEnd) begin
      if (at_start && anchor_cfg) push_text("^");
      if (anchor_cfg) push_text("$");
      item_bytes.push_back(8'h00);
      at_start       = 1'b1;
      after_bracket  = 1'b0;
      escape_pending = 1'b0;
    end else begin
      first = at_start;
      brk   = after_bracket;
      esc   = escape_pending;
      if (first && anchor_cfg) push_text("^");
      at_start       = 1'b0;
      after_bracket  = 1'b0;
      escape_pending = 1'b0;
      if (esc) begin
        if (c == ChN) item_bytes.push_back(ChBslash);
        item_bytes.push_back(c);
      end else if (brk && c == ChBang) begin
        push_text("^");
      end else if (first && c == ChStar) begin
        push_text(LeadStar);
      end else if (first && c == ChQuest) begin
        push_text(LeadQuest);
      end else if (c == ChQuest) begin
        push_text(".");
      end else if (c == ChStar) begin
        push_text(".*");
      end else if (c == ChOpen) begin
        item_bytes.push_back(ChOpen);
        after_bracket = 1'b1;
      end else if (c == ChBslash) begin
        item_bytes.push_back(ChBslash);
        escape_pending = 1'b1;
      end else if (is_meta(c)) begin
        item_bytes.push_back(ChBslash);
        item_bytes.push_back(c);
      end else begin
        item_bytes.push_back(c);
      end
    end
    foreach (item_bytes[i]) regex_q.push_back('{item_bytes[i], i == item_bytes.size() - 1});
  endtask

  function automatic void add_item(input logic act, input logic [7:0] c);
    glob_item_t it;
    it.act   = act;
    it.ch    = c;
    it.gap   = $urandom_range(0, 3);
    it.drain = ($urandom_range(0, 49) == 0);
    pend_q.push_back(it);
  endfunction

  function automatic void add_pattern(input string s);
    for (int i = 0; i < s.len(); i++) add_item(ActChar, s[i]);
    add_item(ActEnd, 8'($urandom_range(0, 255)));
  endfunction

  function automatic logic [7:0] pick_glob_char();
    if ($urandom_range(0, 9) < 6) return GlobChars[$urandom_range(0, 15)];
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly short patterns closed by an end item; the last one may stay open
  function automatic void add_random(input int count);
    int n;
    int len;
    n = 0;
    while (n < count) begin
      len = $urandom_range(0, 10);
      for (int i = 0; i < len && n < count; i++) begin
        add_item(ActChar, pick_glob_char());
        n++;
      end
      if (n < count) begin
        add_item(ActEnd, 8'($urandom_range(0, 255)));
        n++;
      end
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk); while (pend_q.size() != 0 || pat.valid || !rx_drained);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_anchor(input logic v);
    @(posedge clk);
    cfg.valid        <= 1'b1;
    cfg.anchor_whole <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid  <= 1'b0;
    anchor_cfg = v;
  endtask

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      pat.valid   <= 1'b0;
      pat.action  <= ActChar;
      pat.char_in <= '0;
      gap_waited  <= 0;
    end else if (!pat.valid || pat.ready) begin
      if (pend_q.size() != 0 && (!pend_q[0].drain || (!pat.valid && rx_drained))) begin
        if (gap_waited < (no_idle ? 0 : pend_q[0].gap)) begin
          pat.valid  <= 1'b0;
          gap_waited <= gap_waited + 1;
        end else begin
          cur_item = pend_q.pop_front();
          pat.valid   <= 1'b1;
          pat.action  <= cur_item.act;
          pat.char_in <= cur_item.ch;
          gap_waited  <= 0;
        end
      end else begin
        pat.valid <= 1'b0;
      end
    end
  end

  // monitor: prediction on input accept, check on output accept
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rx.ready   <= 1'b0;
      stall_left <= 0;
      rx_drained <= 1'b1;
    end else begin
      if (pat.valid && pat.ready) expand_glob_item(pat.action, pat.char_in);
      next_stall = stall_left;
      if (rx.valid && rx.ready) begin
        if (regex_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b", rx.out_byte, rx.out_last));
        end else begin
          want = regex_q.pop_front();
          if (rx.out_byte !== want.rx_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h", rx.out_byte, want.rx_byte));
          if (rx.out_last !== want.last)
            report_mismatch($sformatf("out_last %0b, expected %0b on byte %02h",
                                      rx.out_last, want.last, want.rx_byte));
        end
        next_stall = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (next_stall > 0) begin
        rx.ready   <= 1'b0;
        stall_left <= next_stall - 1;
      end else begin
        rx.ready   <= 1'b1;
        stall_left <= 0;
      end
      rx_drained <= (regex_q.size() == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((pat.valid && pat.ready) || (rx.valid && rx.ready) || (cfg.valid && cfg.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
        $display("glob_to_regex_converter verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    err_count      = 0;
    quiet_cycles   = 0;
    no_idle        = 1'b0;
    anchor_cfg     = 1'b1;
    at_start       = 1'b1;
    after_bracket  = 1'b0;
    escape_pending = 1'b0;
    cfg.valid        <= 1'b0;
    cfg.anchor_whole <= 1'b1;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, anchoring at its reset value
    add_pattern("*?*[!");
    add_pattern("?\\n\\*\\");
    add_pattern("");
    add_item(ActChar, 8'h00);
    add_item(ActChar, 8'hFF);
    add_pattern("$^{}().+");
    add_random(60);
    add_item(ActChar, "x");
    wait_idle();

    // anchoring off, changed with a pattern still open
    write_anchor(1'b0);
    @(negedge clk);
    add_pattern("");
    add_random(110);
    pend_q[pend_q.size() / 2].drain = 1'b1;
    wait_idle();

    write_anchor(1'b1);
    @(negedge clk);
    no_idle = 1'b1;
    add_random(110);
    wait_idle();

    write_anchor(1'b0);
    @(negedge clk);
    no_idle = 1'b0;
    add_random(80);
    wait_idle();

    write_anchor(1'b1);
    @(negedge clk);
    add_random(60);
    wait_idle();

    if (regex_q.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never arrived", regex_q.size()));
    if (err_count == 0) begin
      $display("glob_to_regex_converter verification clean");
    end else begin
      $display("glob_to_regex_converter verification failed");
    end
    $finish;
  end

endmodule
